@@ design/qtid_pkg.sv @@
// ----------------------------------------------------------------------------
// qtid_pkg: shared types and constants
// Field widths, action and register codes, and the register bundle of the
// quadratic table interpolation unit.
// ----------------------------------------------------------------------------
package qtid_pkg;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 8;

    // action, key and sample bits of a queued word (the fraction comes after)
    localparam int ITEM_FIXED_W = 1 + INDEX_W + DATA_W;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INTERVAL = 2'd2;

    localparam logic [INDEX_W-1:0] LAST_INTERVAL_RESET = 10'd1020;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic        [DATA_W-1:0] inverse_spacing;
        logic        [INDEX_W-1:0] last_interval;
    } t_cfg_regs;

endpackage

@@ design/qtid_front.sv @@
// ----------------------------------------------------------------------------
// qtid_front: accept and classify
// Registers each accepted word, scales the position offset by the inverse
// spacing and splits it into a clamped interval index and fraction.
// ----------------------------------------------------------------------------
module qtid_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  qtid_pkg::t_cfg_regs                           i_cfg,
    input  logic                                          i_accept,
    input  logic                                          i_action,
    input  logic [qtid_pkg::INDEX_W-1:0]                  i_entry_index,
    input  logic signed [qtid_pkg::DATA_W-1:0]            i_entry_value,
    input  logic signed [qtid_pkg::DATA_W-1:0]            i_position,
    output logic                                          o_push,
    output logic [qtid_pkg::ITEM_FIXED_W+FRAC_BITS-1:0]   o_item
);

    localparam int QW = 2 * qtid_pkg::DATA_W - 2 * FRAC_BITS;

    logic signed [qtid_pkg::DATA_W:0]   a_diff;
    logic [qtid_pkg::DATA_W-1:0]        a_off;

    logic                               r_a_valid;
    logic                               r_a_act;
    logic [qtid_pkg::INDEX_W-1:0]       r_a_key;
    logic [qtid_pkg::DATA_W-1:0]        r_a_val;
    logic [qtid_pkg::DATA_W-1:0]        r_a_off;

    logic                               r_b_valid;
    logic                               r_b_act;
    logic [qtid_pkg::INDEX_W-1:0]       r_b_key;
    logic [qtid_pkg::DATA_W-1:0]        r_b_val;
    logic [2*qtid_pkg::DATA_W-1:0]      r_b_prod;

    logic [QW-1:0]                      b_idx_full;
    logic                               b_over;
    logic [qtid_pkg::INDEX_W-1:0]       b_idx;
    logic [FRAC_BITS-1:0]               b_t;
    logic [qtid_pkg::INDEX_W-1:0]       b_key;

    // offset from origin, clamped at zero
    always_comb begin
        a_diff = 33'(i_position) - 33'(i_cfg.origin_x);
        a_off  = (a_diff > 33'sd0) ? a_diff[qtid_pkg::DATA_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_act <= i_action;
            r_a_key <= i_entry_index;
            r_a_val <= i_entry_value;
            r_a_off <= a_off;
        end
        r_b_act  <= r_a_act;
        r_b_key  <= r_a_key;
        r_b_val  <= r_a_val;
        r_b_prod <= r_a_off * i_cfg.inverse_spacing;
    end

    // index / fraction split, clamp to last interval
    always_comb begin
        b_idx_full = r_b_prod[2*qtid_pkg::DATA_W-1:2*FRAC_BITS];
        b_over     = b_idx_full > QW'(i_cfg.last_interval);
        b_idx      = b_over ? i_cfg.last_interval : b_idx_full[qtid_pkg::INDEX_W-1:0];
        b_t        = b_over ? '0 : r_b_prod[2*FRAC_BITS-1:FRAC_BITS];
        b_key      = (r_b_act == qtid_pkg::ACT_EVAL) ? b_idx : r_b_key;
    end

    assign o_push = r_b_valid;
    assign o_item = {r_b_act, b_key, r_b_val, b_t};

endmodule

@@ design/qtid_queue.sv @@
// ----------------------------------------------------------------------------
// qtid_queue: work queue
// Small FIFO between the front and the back; the writer never overfills it.
// ----------------------------------------------------------------------------
module qtid_queue #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ design/qtid_back.sv @@
// ----------------------------------------------------------------------------
// qtid_back: table store and interpolation pipeline
// Four interleaved banks hold the table so the four stencil samples are read
// in the same cycle; then difference, multiply, round and saturate stages.
// ----------------------------------------------------------------------------
module qtid_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [qtid_pkg::DATA_W-1:0]                   i_inv,
    input  logic                                          i_empty,
    input  logic [qtid_pkg::ITEM_FIXED_W+FRAC_BITS-1:0]   i_item,
    output logic                                          o_pop,
    input  logic                                          i_out_ready,
    output logic                                          o_out_valid,
    output logic signed [qtid_pkg::DATA_W-1:0]            o_func_value,
    output logic signed [qtid_pkg::DATA_W-1:0]            o_func_slope
);

    localparam int F      = FRAC_BITS;
    localparam int ITEM_W = qtid_pkg::ITEM_FIXED_W + FRAC_BITS;
    localparam int AW     = $clog2(TABLE_DEPTH) + 1;
    localparam int ROWS   = (TABLE_DEPTH + 3) / 4;
    localparam int RW     = $clog2(ROWS);
    localparam int PW     = 36 + F;          // t * difference
    localparam int SW     = 37 + F;          // bracket sums before rounding
    localparam int IW     = 37;              // rounded brackets
    localparam int FW     = F + 1 + IW;      // t * inner
    localparam int XW     = 39;              // value before saturation
    localparam int TW     = IW + qtid_pkg::DATA_W + 1;

    localparam logic signed [SW-1:0] HALF_F    = SW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] HALF_F_M1 = HALF_F - SW'(1);
    localparam logic signed [FW-1:0] HALF_2    = FW'(1) <<< F;
    localparam logic signed [FW-1:0] HALF_2_M1 = HALF_2 - FW'(1);
    localparam logic [TW-1:0]        ROUND_S   = TW'(1) << F;

    // queue head fields
    logic                               it_act;
    logic [qtid_pkg::INDEX_W-1:0]       it_key;
    logic [qtid_pkg::DATA_W-1:0]        it_val;
    logic [F-1:0]                       it_t;

    logic                               en;
    logic                               pop;
    logic                               rd_en;
    logic                               wr_en;
    logic [AW-1:0]                      base_addr;
    logic [AW-1:0]                      room;
    logic [1:0]                         sel;

    // read stage
    logic signed [qtid_pkg::DATA_W-1:0] r_rd [4];
    logic                               r_c_valid;
    logic [F-1:0]                       r_c_t;
    logic [1:0]                         r_c_base;
    logic [1:0]                         r_c_sel;

    // difference stage
    logic signed [qtid_pkg::DATA_W-1:0] lane [4];
    logic [1:0]                         mk;
    logic signed [33:0]                 d_g1;
    logic signed [33:0]                 d_g2;
    logic signed [34:0]                 d_dg;
    logic signed [34:0]                 d_curv;
    logic                               r_d_valid;
    logic [F-1:0]                       r_d_t;
    logic signed [qtid_pkg::DATA_W-1:0] r_d_b;
    logic signed [33:0]                 r_d_g1;
    logic signed [34:0]                 r_d_dg;
    logic signed [34:0]                 r_d_curv;

    // product stage
    logic signed [F:0]                  e_ts;
    logic                               r_e_valid;
    logic [F-1:0]                       r_e_t;
    logic signed [qtid_pkg::DATA_W-1:0] r_e_b;
    logic signed [33:0]                 r_e_g1;
    logic signed [PW-1:0]               r_e_pc;
    logic signed [PW-1:0]               r_e_pd;

    // bracket rounding stage
    logic signed [SW-1:0]               f_isum;
    logic signed [SW-1:0]               f_ssum;
    logic signed [SW-1:0]               f_ir;
    logic signed [SW-1:0]               f_sr;
    logic                               r_f_valid;
    logic [F-1:0]                       r_f_t;
    logic signed [qtid_pkg::DATA_W-1:0] r_f_b;
    logic signed [IW-1:0]               r_f_inner;
    logic signed [IW-1:0]               r_f_sbr;

    // final products
    logic signed [F:0]                  g_ts;
    logic [IW-1:0]                      g_mag;
    logic                               r_g_valid;
    logic signed [qtid_pkg::DATA_W-1:0] r_g_b;
    logic signed [FW-1:0]               r_g_pf;
    logic [IW+15:0]                     r_g_phi;
    logic [IW+15:0]                     r_g_plo;
    logic                               r_g_neg;

    // output stage
    logic signed [FW-1:0]               h_fr;
    logic signed [XW-1:0]               h_fsum;
    logic signed [qtid_pkg::DATA_W-1:0] h_value;
    logic [TW-1:0]                      h_tot;
    logic [TW-1:0]                      h_sl;
    logic                               h_big;
    logic signed [qtid_pkg::DATA_W-1:0] h_slope;
    logic                               r_h_valid;
    logic signed [qtid_pkg::DATA_W-1:0] r_h_value;
    logic signed [qtid_pkg::DATA_W-1:0] r_h_slope;

    assign it_act = i_item[ITEM_W-1];
    assign it_key = i_item[ITEM_W-2 -: qtid_pkg::INDEX_W];
    assign it_val = i_item[F+qtid_pkg::DATA_W-1:F];
    assign it_t   = i_item[F-1:0];

    // whole back pipe moves unless the output word is stalled
    assign en    = !r_h_valid || i_out_ready;
    assign pop   = en && !i_empty;
    assign rd_en = pop && (it_act == qtid_pkg::ACT_EVAL);
    assign wr_en = pop && (it_act == qtid_pkg::ACT_WRITE) && (int'(it_key) < TABLE_DEPTH);
    assign o_pop = pop;

    // window start clamped to the last word; lanes past the end repeat it
    always_comb begin
        base_addr = (int'(it_key) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1) : AW'(it_key);
        room      = AW'(TABLE_DEPTH - 1) - base_addr;
        sel       = (room > AW'(3)) ? 2'd3 : room[1:0];
    end

    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        logic [qtid_pkg::DATA_W-1:0] r_mem [ROWS];
        logic [1:0]                  lane_ofs;
        logic [AW-1:0]               rd_addr;
        logic [AW-1:0]               rd_row_full;
        logic [RW-1:0]               rd_row;

        always_comb begin
            lane_ofs    = 2'(gb) - base_addr[1:0];
            rd_addr     = base_addr + AW'(lane_ofs);
            rd_row_full = rd_addr >> 2;
            rd_row      = (int'(rd_row_full) >= ROWS) ? RW'(ROWS - 1) : RW'(rd_row_full);
        end

        always_ff @(posedge i_clk) begin
            if (wr_en && (it_key[1:0] == 2'(gb))) begin
                r_mem[RW'(it_key >> 2)] <= it_val;
            end
            if (rd_en) begin
                r_rd[gb] <= r_mem[rd_row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= rd_en;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
        end
    end

    // stencil samples and differences
    always_comb begin
        mk = 2'd0;
        for (int k = 0; k < 4; k++) begin
            mk      = (2'(k) > r_c_sel) ? r_c_sel : 2'(k);
            lane[k] = r_rd[2'(r_c_base + mk)];
        end
        d_g1   = 34'(lane[2]) - 34'(lane[0]);
        d_g2   = 34'(lane[3]) - 34'(lane[1]);
        d_dg   = 35'(d_g2) - 35'(d_g1);
        d_curv = 35'(lane[2]) + 35'(lane[0]) - (35'(lane[1]) <<< 1);
    end

    assign e_ts = $signed({1'b0, r_d_t});

    // bracket sums, rounded to nearest, ties away from zero
    always_comb begin
        f_isum = (SW'(r_e_g1) <<< F) + SW'(r_e_pc);
        f_ssum = (SW'(r_e_g1) <<< F) + SW'(r_e_pd);
        f_ir   = f_isum + (f_isum[SW-1] ? HALF_F_M1 : HALF_F);
        f_sr   = f_ssum + (f_ssum[SW-1] ? HALF_F_M1 : HALF_F);
    end

    assign g_ts  = $signed({1'b0, r_f_t});
    assign g_mag = r_f_sbr[IW-1] ? IW'(-r_f_sbr) : IW'(r_f_sbr);

    // final rounding and saturation
    always_comb begin
        h_fr   = (r_g_pf + (r_g_pf[FW-1] ? HALF_2_M1 : HALF_2)) >>> (F + 1);
        h_fsum = XW'(h_fr) + XW'(r_g_b);
        if (h_fsum > XW'(qtid_pkg::DATA_MAX)) begin
            h_value = qtid_pkg::DATA_MAX;
        end else if (h_fsum < XW'(qtid_pkg::DATA_MIN)) begin
            h_value = qtid_pkg::DATA_MIN;
        end else begin
            h_value = h_fsum[qtid_pkg::DATA_W-1:0];
        end

        h_tot = (TW'(r_g_phi) << 16) + TW'(r_g_plo) + ROUND_S;
        h_sl  = h_tot >> (F + 1);
        h_big = |h_sl[TW-1:qtid_pkg::DATA_W-1];
        if (r_g_neg) begin
            h_slope = h_big ? qtid_pkg::DATA_MIN : -$signed(h_sl[qtid_pkg::DATA_W-1:0]);
        end else begin
            h_slope = h_big ? qtid_pkg::DATA_MAX : $signed(h_sl[qtid_pkg::DATA_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_t     <= it_t;
            r_c_base  <= base_addr[1:0];
            r_c_sel   <= sel;

            r_d_t     <= r_c_t;
            r_d_b     <= lane[1];
            r_d_g1    <= d_g1;
            r_d_dg    <= d_dg;
            r_d_curv  <= d_curv;

            r_e_t     <= r_d_t;
            r_e_b     <= r_d_b;
            r_e_g1    <= r_d_g1;
            r_e_pc    <= e_ts * r_d_curv;
            r_e_pd    <= e_ts * r_d_dg;

            r_f_t     <= r_e_t;
            r_f_b     <= r_e_b;
            r_f_inner <= IW'(f_ir >>> F);
            r_f_sbr   <= IW'(f_sr >>> F);

            r_g_b     <= r_f_b;
            r_g_pf    <= g_ts * r_f_inner;
            r_g_phi   <= g_mag * i_inv[31:16];
            r_g_plo   <= g_mag * i_inv[15:0];
            r_g_neg   <= r_f_sbr[IW-1];

            r_h_value <= h_value;
            r_h_slope <= h_slope;
        end
    end

    assign o_out_valid  = r_h_valid;
    assign o_func_value = r_h_value;
    assign o_func_slope = r_h_slope;

endmodule

@@ design/quadratic_table_interp_deriv_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_table_interp_deriv_unit: table interpolation with derivative
// Quadratic interpolation and four-point slope over a uniformly sampled,
// writable table in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel while input ready is high
// and gives one result per clock on the output channel while output ready
// is high; a load word (action 0) writes one table entry and gives no
// result, an evaluate word (action 1) gives one result. An evaluate word
// passes the front offset register, the 32x32 scale multiply register and
// the work queue, then the banked table read, differences, products, bracket
// rounding, final products and the saturating output register. Four table
// banks, interleaved, supply the four stencil samples in one read. The queue
// holds QUEUE_DEPTH words; input ready drops only when that many words are
// between acceptance and the queue head; in a steady stream three are there.
// Entries read before ever being written return garbage. Configuration
// writes are always ready and must be issued only while the unit is idle.
// ----------------------------------------------------------------------------
module quadratic_table_interp_deriv_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [qtid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qtid_pkg::DATA_W-1:0]           i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_action,
    input  logic [qtid_pkg::INDEX_W-1:0]          i_entry_index,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_entry_value,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_position,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [qtid_pkg::DATA_W-1:0]    o_func_value,
    output logic signed [qtid_pkg::DATA_W-1:0]    o_func_slope
);

    localparam int ITEM_W = qtid_pkg::ITEM_FIXED_W + FRAC_BITS;
    localparam int OCC_W  = $clog2(qtid_pkg::QUEUE_DEPTH + 1);
    localparam logic [qtid_pkg::DATA_W-1:0] INV_RESET =
        qtid_pkg::DATA_W'(64'd1 << FRAC_BITS);

    qtid_pkg::t_cfg_regs r_cfg;

    logic              in_accept;
    logic              push;
    logic [ITEM_W-1:0] push_item;
    logic              q_empty;
    logic [ITEM_W-1:0] q_item;
    logic              pop;

    // words accepted but not yet taken from the queue head
    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;

    // register file; indexes past the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x        <= '0;
            r_cfg.inverse_spacing <= INV_RESET;
            r_cfg.last_interval   <= qtid_pkg::LAST_INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qtid_pkg::CFG_ORIGIN_X: begin
                    r_cfg.origin_x <= i_cfg_data;
                end
                qtid_pkg::CFG_INV_SPACING: begin
                    r_cfg.inverse_spacing <= i_cfg_data;
                end
                qtid_pkg::CFG_LAST_INTERVAL: begin
                    r_cfg.last_interval <= i_cfg_data[qtid_pkg::INDEX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // credit count: the front has no stall, so a word is only taken while
    // the queue is sure to have room for it
    assign o_in_ready = (r_occ < OCC_W'(qtid_pkg::QUEUE_DEPTH));
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_occ = r_occ + OCC_W'(in_accept) - OCC_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    qtid_front #(
        .FRAC_BITS     (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_position    (i_position),
        .o_push        (push),
        .o_item        (push_item)
    );

    qtid_queue #(
        .WIDTH   (ITEM_W),
        .DEPTH   (qtid_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    qtid_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_inv        (r_cfg.inverse_spacing),
        .i_empty      (q_empty),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_func_value (o_func_value),
        .o_func_slope (o_func_slope)
    );

endmodule

@@ design/qtid_checker.sv @@
// ----------------------------------------------------------------------------
// qtid_port_checks: port-level checks
// Reset behavior, pipeline fill time, configuration ready and output stall
// hold, seen from the top-level ports.
// ----------------------------------------------------------------------------
module qtid_port_checks (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_cfg_ready,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [qtid_pkg::DATA_W-1:0]    o_func_value,
    input  logic signed [qtid_pkg::DATA_W-1:0]    o_func_slope
);

    // after reset: nothing pending, queue has room
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stall right after reset");

    // a result needs the full pipe
    a_fill_time: assert property (@(posedge i_clk)
        !i_rst_n |=> ##6 !o_out_valid)
        else $error("result appeared before the pipe could fill");

    // register port never stalls
    a_cfg_ready: assert property (@(posedge i_clk)
        i_rst_n |-> o_cfg_ready)
        else $error("configuration port not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_func_value) && $stable(o_func_slope))
        else $error("stalled result word changed or dropped");

endmodule

bind quadratic_table_interp_deriv_unit qtid_port_checks u_checker (.*);

@@ tb/qtid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtid_checker: result checker for the table interpolation unit
// Mirrors the registers and the sample table from the accepted words,
// predicts every evaluate result and compares results in order.
// ----------------------------------------------------------------------------
module qtid_checker #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [qtid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qtid_pkg::DATA_W-1:0]           i_cfg_data,

    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_action,
    input  logic [qtid_pkg::INDEX_W-1:0]          i_entry_index,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_entry_value,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_position,

    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_func_value,
    input  logic signed [qtid_pkg::DATA_W-1:0]    i_func_slope,

    output int                                    o_error_count,
    output int                                    o_pending
);

    import qtid_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] func_value;
        logic signed [DATA_W-1:0] func_slope;
    } interp_result_t;

    localparam longint          UNIT      = 64'sd1 << FRAC_BITS;
    localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
    localparam longint unsigned SLOPE_CAP = 64'd1 << 40;
    localparam longint unsigned HI_LIMIT  = 64'd1 << 46;

    logic signed [DATA_W-1:0]  sample_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0]  cfg_origin;
    logic        [DATA_W-1:0]  cfg_inv;
    logic        [INDEX_W-1:0] cfg_last;

    interp_result_t expected_interp_q [$];
    int             err_count = 0;

    // divide by 2^k, nearest, ties away from zero
    function automatic longint round_half_away(input longint v, input int k);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : v;
        q   = (mag + (64'd1 << (k - 1))) >> k;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [DATA_W-1:0] saturate(input longint v);
        if (v > longint'(DATA_MAX)) return DATA_MAX;
        if (v < longint'(DATA_MIN)) return DATA_MIN;
        return v[DATA_W-1:0];
    endfunction

    // reads past the end of the store land on the last word
    function automatic longint read_word(input longint unsigned addr);
        if (addr >= longint'(TABLE_DEPTH)) addr = longint'(TABLE_DEPTH - 1);
        return longint'(sample_mem[addr]);
    endfunction

    function automatic interp_result_t compute_interp(input logic signed [DATA_W-1:0] pos_w);
        longint          pos, org, idx, t;
        longint          a, b, c, e, g1, g2, curv, inner, fval, slope_br, slope;
        longint unsigned off, scaled, mag, p_hi, p_lo, total, sl_mag, inv;
        interp_result_t  res;

        pos = longint'(pos_w);
        org = longint'(cfg_origin);
        inv = longint'(cfg_inv) & 64'hFFFF_FFFF;
        off = (pos > org) ? longint'(pos - org) : 64'd0;

        scaled = (off * inv) >> FRAC_BITS;
        idx    = longint'(scaled >> FRAC_BITS);
        t      = longint'(scaled & FRAC_MASK);
        if (idx > longint'(cfg_last)) begin
            idx = longint'(cfg_last);
            t   = 0;
        end

        a = read_word(idx);
        b = read_word(idx + 1);
        c = read_word(idx + 2);
        e = read_word(idx + 3);
        g1   = c - a;
        g2   = e - b;
        curv = c + a - 2 * b;

        inner = round_half_away(g1 * UNIT + t * curv, FRAC_BITS);
        fval  = b + round_half_away(t * inner, FRAC_BITS + 1);

        slope_br = round_half_away(g1 * UNIT + t * (g2 - g1), FRAC_BITS);
        mag  = (slope_br < 0) ? longint'(-slope_br) : slope_br;
        p_hi = mag * (inv >> 16);
        p_lo = mag * (inv & 64'hFFFF);
        if (p_hi >= HI_LIMIT) begin
            sl_mag = SLOPE_CAP;
        end else begin
            total  = (p_hi << 16) + p_lo;
            sl_mag = (total + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
            if (sl_mag > SLOPE_CAP) sl_mag = SLOPE_CAP;
        end
        slope = (slope_br < 0) ? -longint'(sl_mag) : longint'(sl_mag);

        res.func_value = saturate(fval);
        res.func_slope = saturate(slope);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        interp_result_t want;
        if (!i_rst_n) begin
            cfg_origin = '0;
            cfg_inv    = 32'd1 << FRAC_BITS;
            cfg_last   = LAST_INTERVAL_RESET;
            expected_interp_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X:      cfg_origin = i_cfg_data;
                    CFG_INV_SPACING:   cfg_inv    = i_cfg_data;
                    CFG_LAST_INTERVAL: cfg_last   = i_cfg_data[INDEX_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_WRITE) begin
                    if (i_entry_index < TABLE_DEPTH) sample_mem[i_entry_index] = i_entry_value;
                end else begin
                    expected_interp_q.push_back(compute_interp(i_position));
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_interp_q.size() == 0) begin
                    $error("unexpected result: func_value %0d func_slope %0d",
                           i_func_value, i_func_slope);
                    err_count++;
                end else begin
                    want = expected_interp_q.pop_front();
                    if (i_func_value !== want.func_value) begin
                        $error("func_value mismatch: expected %0d, actual %0d",
                               want.func_value, i_func_value);
                        err_count++;
                    end
                    if (i_func_slope !== want.func_slope) begin
                        $error("func_slope mismatch: expected %0d, actual %0d",
                               want.func_slope, i_func_slope);
                        err_count++;
                    end
                end
            end
        end
        o_pending     <= expected_interp_q.size();
        o_error_count <= err_count;
    end

endmodule

@@ tb/tb_quadratic_table_interp_deriv_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_table_interp_deriv_unit: testbench for the interpolation unit
// Loads the whole table, runs directed corner words, then random load and
// evaluate traffic under several register settings with random gaps and
// output stalls; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_quadratic_table_interp_deriv_unit;

    import qtid_pkg::*;

    localparam int     TABLE_DEPTH   = 1024;
    localparam int     CLK_HALF      = 10;
    localparam int     SETTLE_CYCLES = 16;      // margin for load words still in the pipe after draining
    localparam int     LONG_HOLD     = 150;     // receiver hold-off for the fill-up test
    localparam longint TIMEOUT_NS    = 30_000_000;

    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                     clk = 1'b0;
    logic                     rst_n;

    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    logic                     in_valid;
    logic                     in_ready;
    logic                     action;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] position;

    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] func_value;
    logic signed [DATA_W-1:0] func_slope;

    int errors;
    int pending;

    // stimulus-side copy of the registers, used only to aim positions
    logic signed [DATA_W-1:0] cur_origin;
    logic        [DATA_W-1:0] cur_inv;
    logic        [INDEX_W-1:0] cur_last;

    bit sender_burst;           // no gaps between input words while set
    bit long_hold_req = 1'b0;   // asks the receiver for one long hold-off

    always #(CLK_HALF) clk = ~clk;

    quadratic_table_interp_deriv_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_entry_index (entry_index),
        .i_entry_value (entry_value),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_func_value  (func_value),
        .o_func_slope  (func_slope)
    );

    qtid_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_action      (action),
        .i_entry_index (entry_index),
        .i_entry_value (entry_value),
        .i_position    (position),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_func_value  (func_value),
        .i_func_slope  (func_slope),
        .o_error_count (errors),
        .o_pending     (pending)
    );

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (sender_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // table sample: small values, full range, or one of the extremes
    function automatic logic signed [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return DATA_W'(longint'($urandom_range(0, 2097152)) - 64'sd1048576);
        if (r < 80) return $urandom;
        case ($urandom_range(0, 4))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // Most positions are aimed into the table (index up to one past the
    // last interval, random fraction); the rest are near or below the
    // origin, full-range, or extremes.
    function automatic logic signed [DATA_W-1:0] pick_position();
        int              r;
        longint unsigned target, off;
        longint          p;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        if (r < 25) begin
            p = longint'(cur_origin) + longint'($urandom_range(0, 2097152)) - 64'sd1048576;
        end else if (r < 30) begin
            case ($urandom_range(0, 3))
                0:       return DATA_MIN;
                1:       return DATA_MAX;
                2:       return cur_origin;
                default: return cur_origin - 1;
            endcase
        end else begin
            if (cur_inv == 0) return $urandom;
            target = longint'($urandom_range(0, cur_last + 1));
            off = ((target << 32) + longint'($urandom)) / (longint'(cur_inv) & 64'hFFFF_FFFF);
            p = longint'(cur_origin) + longint'(off);
        end
        if (p > longint'(DATA_MAX) || p < longint'(DATA_MIN)) return $urandom;
        return p[DATA_W-1:0];
    endfunction

    // Offer one word after the given gap and return at the edge that takes it.
    // With no gap valid simply stays high and only the payload moves on.
    task automatic send_word(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val,
                             input logic signed [DATA_W-1:0] pos, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        entry_value <= val;
        position    <= pos;
        do @(posedge clk); while (!in_ready);
    endtask

    // one register write, then idle with valid low so valid never toggles in a step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:      cur_origin = data;
            CFG_INV_SPACING:   cur_inv    = data;
            CFG_LAST_INTERVAL: cur_last   = data[INDEX_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // stop offering words, let every expected result out, then let load
    // words still in the pipe finish before touching the registers
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random mix, mostly evaluates; bursts without gaps in some stretches
    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 12)
                send_word(ACT_WRITE, INDEX_W'($urandom), pick_sample(), $urandom,
                          pick_gap());
            else
                send_word(ACT_EVAL, INDEX_W'($urandom), $urandom, pick_position(),
                          pick_gap());
        end
        sender_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready with short and long stalls, free-running
    // stretches, and one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int r;
        int cyc;
        bit free_run;
        hold_left = 0;
        cyc       = 0;
        free_run  = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 200 == 0) free_run = ($urandom_range(0, 3) == 0);
            if (hold_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (free_run) begin
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    hold_left = (r < 90) ? $urandom_range(0, 2) :
                                (r < 98) ? $urandom_range(3, 10) : $urandom_range(20, 50);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        longint walk;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ACT_WRITE;
        entry_index = '0;
        entry_value = '0;
        position    = '0;
        cur_origin  = '0;
        cur_inv     = 32'h0001_0000;
        cur_last    = LAST_INTERVAL_RESET;
        sender_burst = 1'b0;
        walk        = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every address first so no evaluation can touch an unwritten
        // word. The table is a random walk (smooth curvature) with the odd
        // jump to a wild or extreme value.
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if ($urandom_range(0, 99) < 4)
                walk = longint'(pick_sample());
            else
                walk = walk + longint'($urandom_range(0, 524288)) - 64'sd262144;
            if (walk > longint'(DATA_MAX)) walk = longint'(DATA_MAX);
            if (walk < longint'(DATA_MIN)) walk = longint'(DATA_MIN);
            send_word(ACT_WRITE, INDEX_W'(k), walk[DATA_W-1:0], $urandom, pick_gap());
        end

        // Directed words at the reset settings (origin 0, spacing 1.0, last 1020)
        send_word(ACT_EVAL, '0, '0, 32'sh0000_0000, pick_gap());  // at the origin
        send_word(ACT_EVAL, '1, '1, 32'shFFFF_FFFF, pick_gap());  // just below origin
        send_word(ACT_EVAL, '0, '0, DATA_MIN, pick_gap());        // far below origin
        send_word(ACT_EVAL, '1, '1, DATA_MAX, pick_gap());        // far past last interval
        send_word(ACT_EVAL, '0, '0, 32'sh03FC_8000, pick_gap());  // inside last interval
        send_word(ACT_EVAL, '0, '0, 32'sh03FD_0000, pick_gap());  // one past: clamp, t = 0
        send_word(ACT_EVAL, '0, '0, 32'sh0005_FFFF, pick_gap());  // largest fraction
        send_word(ACT_EVAL, '0, '0, 32'sh000A_8000, pick_gap());  // half way
        // alternating extremes in the first stencil: largest curvature, zero slope
        send_word(ACT_WRITE, 10'd0, DATA_MAX, '0, pick_gap());
        send_word(ACT_WRITE, 10'd1, DATA_MIN, '1, pick_gap());
        send_word(ACT_WRITE, 10'd2, DATA_MAX, '0, pick_gap());
        send_word(ACT_WRITE, 10'd3, DATA_MIN, '1, pick_gap());
        send_word(ACT_EVAL, '0, '0, 32'sh0000_8000, pick_gap());
        send_word(ACT_EVAL, '0, '0, 32'sh0000_FFFF, 0);
        // evaluate right behind a load of a word it reads
        send_word(ACT_WRITE, 10'd6, DATA_MIN, '0, pick_gap());
        send_word(ACT_EVAL, '0, '0, 32'sh0005_4000, 0);
        // top store addresses, then the last interval that reads them
        send_word(ACT_WRITE, 10'd1023, DATA_MAX, '0, pick_gap());
        send_word(ACT_WRITE, 10'd1022, DATA_MIN, '0, 0);
        send_word(ACT_EVAL, '0, '0, 32'sh03FC_0000, 0);

        // Unit spacing, all three registers written. The receiver holds off
        // for a long stretch while words keep coming, so the work queue fills
        // and input ready has to drop.
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, 32'h0000_0000);
        write_reg(CFG_INV_SPACING, 32'h0001_0000);
        write_reg(CFG_LAST_INTERVAL, 32'd1020);
        long_hold_req = 1'b1;
        repeat (48) send_word(ACT_EVAL, INDEX_W'($urandom), $urandom, pick_position(), 0);
        run_random(170);

        // Lowest origin, spacing 64, last interval past the declared range:
        // stencil reads run off the end of the store.
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, DATA_MIN);
        write_reg(CFG_INV_SPACING, 32'h0000_0400);
        write_reg(CFG_LAST_INTERVAL, {22'($urandom), 10'd1023});
        send_word(ACT_EVAL, '0, '0, 32'sh7FE0_0000, pick_gap());  // index 1023, t = 0.5
        send_word(ACT_EVAL, '0, '0, DATA_MAX, pick_gap());
        run_random(130);

        // Highest origin with the largest inverse spacing: everything clamps
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, DATA_MAX);
        write_reg(CFG_INV_SPACING, 32'hFFFF_FFFF);
        write_reg(CFG_LAST_INTERVAL, 32'd1020);
        run_random(40);

        // zero inverse spacing: index and fraction zero, slope zero
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, 32'hFFF0_0000);
        write_reg(CFG_INV_SPACING, 32'h0000_0000);
        run_random(40);

        // single usable interval
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, 32'h0000_0000);
        write_reg(CFG_INV_SPACING, 32'h0002_0000);
        write_reg(CFG_LAST_INTERVAL, 32'd0);
        run_random(60);

        // random settings; spacing kept so most positions land in the table
        repeat (3) begin
            drain_and_settle();
            write_reg(CFG_ORIGIN_X, $urandom);
            write_reg(CFG_INV_SPACING, $urandom_range(32'h0000_1000, 32'h0040_0000));
            write_reg(CFG_LAST_INTERVAL, {22'($urandom), 10'($urandom)});
            run_random(80);
        end

        // lowest origin with the largest inverse spacing: slope saturation
        drain_and_settle();
        write_reg(CFG_ORIGIN_X, DATA_MIN);
        write_reg(CFG_INV_SPACING, 32'hFFFF_FFFF);
        write_reg(CFG_LAST_INTERVAL, 32'd1020);
        run_random(40);

        // write to the unmapped index must change nothing
        drain_and_settle();
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_ORIGIN_X, 32'hFFF0_0000);
        write_reg(CFG_INV_SPACING, 32'h0004_0000);
        write_reg(CFG_LAST_INTERVAL, 32'd500);
        run_random(60);

        drain_and_settle();
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ quadratic_table_interp_deriv_unit.f @@
design/qtid_pkg.sv
design/qtid_front.sv
design/qtid_queue.sv
design/qtid_back.sv
design/quadratic_table_interp_deriv_unit.sv
design/qtid_checker.sv
tb/qtid_checker.sv
tb/tb_quadratic_table_interp_deriv_unit.sv
